[rtl/lcdns_pkg.sv]
// Types, constants and microcode ROM of the LCD nibble write sequencer.
package lcdns_pkg;

  localparam int unsigned PC_W   = 5;
  localparam int unsigned DIGITS = 5;
  localparam int unsigned CNT_W  = $clog2(DIGITS + 1);

  typedef logic [PC_W-1:0] pc_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    OP_COMMAND   = 2'd0,
    OP_CHARACTER = 2'd1,
    OP_NUMBER    = 2'd2,
    OP_INIT      = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ACT_WAIT,
    ACT_EMIT,
    ACT_DIV,
    ACT_JUMP
  } act_e;

  typedef enum logic [1:0] {
    SRC_VALUE,
    SRC_CONST,
    SRC_DIGIT
  } src_e;

  typedef enum logic [1:0] {
    LAST_NO,
    LAST_YES,
    LAST_NO_DIGITS,
    LAST_ONE_DIGIT
  } last_e;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_DIV_MORE,
    COND_SAME_NUMBER,
    COND_NO_DIGITS,
    COND_MORE_DIGITS
  } cond_e;

  typedef struct packed {
    act_e        act;
    src_e        src;
    logic        hi;
    logic        rs;
    logic        pop;
    last_e       last;
    cond_e       cond;
    pc_t         target;
    logic [7:0]  konst;
  } uword_t;

  typedef struct packed {
    logic load;
    logic step;
    logic pop;
  } dig_ctrl_t;

  typedef struct packed {
    logic       more;
    cnt_t       count;
    logic [3:0] top;
  } dig_stat_t;

  localparam pc_t PC_IDLE      = pc_t'(0);
  localparam pc_t PC_COMMAND   = pc_t'(1);
  localparam pc_t PC_CHARACTER = pc_t'(3);
  localparam pc_t PC_INIT      = pc_t'(5);
  localparam pc_t PC_NUMBER    = pc_t'(13);
  localparam pc_t PC_DIGITS    = pc_t'(17);
  localparam pc_t PC_DIGIT_OUT = pc_t'(18);

  localparam logic [7:0]  CMD_CLEAR    = 8'h01;
  localparam logic [7:0]  CMD_FUNCTION = 8'h28;
  localparam logic [7:0]  CMD_ENTRY    = 8'h06;
  localparam logic [7:0]  CMD_DISPLAY  = 8'h0F;
  localparam logic [3:0]  ASCII_DIGIT_HI = 4'h3;
  localparam logic [16:0] DIV10_RECIP  = 17'd52429;
  localparam int unsigned DIV10_SHIFT  = 19;

  function automatic uword_t uw(act_e act, src_e src, logic hi, logic rs, logic pop,
                                last_e last, cond_e cond, pc_t target, logic [7:0] konst);
    uword_t w;
    w.act    = act;
    w.src    = src;
    w.hi     = hi;
    w.rs     = rs;
    w.pop    = pop;
    w.last   = last;
    w.cond   = cond;
    w.target = target;
    w.konst  = konst;
    return w;
  endfunction

  function automatic pc_t entry(op_e op);
    pc_t p;
    unique case (op)
      OP_COMMAND:   p = PC_COMMAND;
      OP_CHARACTER: p = PC_CHARACTER;
      OP_NUMBER:    p = PC_NUMBER;
      OP_INIT:      p = PC_INIT;
      default:      p = PC_IDLE;
    endcase
    return p;
  endfunction

  function automatic uword_t ucode(pc_t pc);
    uword_t w;
    unique case (pc)
      5'd0:  w = uw(ACT_WAIT, SRC_VALUE, 1'b0, 1'b0, 1'b0, LAST_NO, COND_NEXT, PC_IDLE, 8'h00);
      5'd1:  w = uw(ACT_EMIT, SRC_VALUE, 1'b1, 1'b0, 1'b0, LAST_NO, COND_NEXT, PC_IDLE, 8'h00);
      5'd2:  w = uw(ACT_EMIT, SRC_VALUE, 1'b0, 1'b0, 1'b0, LAST_YES, COND_ALWAYS, PC_IDLE,
                    8'h00);
      5'd3:  w = uw(ACT_EMIT, SRC_VALUE, 1'b1, 1'b1, 1'b0, LAST_NO, COND_NEXT, PC_IDLE, 8'h00);
      5'd4:  w = uw(ACT_EMIT, SRC_VALUE, 1'b0, 1'b1, 1'b0, LAST_YES, COND_ALWAYS, PC_IDLE,
                    8'h00);
      5'd5:  w = uw(ACT_EMIT, SRC_CONST, 1'b1, 1'b0, 1'b0, LAST_NO, COND_NEXT, PC_IDLE,
                    CMD_CLEAR);
      5'd6:  w = uw(ACT_EMIT, SRC_CONST, 1'b0, 1'b0, 1'b0, LAST_NO, COND_NEXT, PC_IDLE,
                    CMD_CLEAR);
      5'd7:  w = uw(ACT_EMIT, SRC_CONST, 1'b1, 1'b0, 1'b0, LAST_NO, COND_NEXT, PC_IDLE,
                    CMD_FUNCTION);
      5'd8:  w = uw(ACT_EMIT, SRC_CONST, 1'b0, 1'b0, 1'b0, LAST_NO, COND_NEXT, PC_IDLE,
                    CMD_FUNCTION);
      5'd9:  w = uw(ACT_EMIT, SRC_CONST, 1'b1, 1'b0, 1'b0, LAST_NO, COND_NEXT, PC_IDLE,
                    CMD_ENTRY);
      5'd10: w = uw(ACT_EMIT, SRC_CONST, 1'b0, 1'b0, 1'b0, LAST_NO, COND_NEXT, PC_IDLE,
                    CMD_ENTRY);
      5'd11: w = uw(ACT_EMIT, SRC_CONST, 1'b1, 1'b0, 1'b0, LAST_NO, COND_NEXT, PC_IDLE,
                    CMD_DISPLAY);
      5'd12: w = uw(ACT_EMIT, SRC_CONST, 1'b0, 1'b0, 1'b0, LAST_YES, COND_ALWAYS, PC_IDLE,
                    CMD_DISPLAY);
      5'd13: w = uw(ACT_DIV, SRC_VALUE, 1'b0, 1'b0, 1'b0, LAST_NO, COND_DIV_MORE, PC_NUMBER,
                    8'h00);
      5'd14: w = uw(ACT_JUMP, SRC_VALUE, 1'b0, 1'b0, 1'b0, LAST_NO, COND_SAME_NUMBER,
                    PC_DIGITS, 8'h00);
      5'd15: w = uw(ACT_EMIT, SRC_CONST, 1'b1, 1'b0, 1'b0, LAST_NO, COND_NEXT, PC_IDLE,
                    CMD_CLEAR);
      5'd16: w = uw(ACT_EMIT, SRC_CONST, 1'b0, 1'b0, 1'b0, LAST_NO_DIGITS, COND_NEXT, PC_IDLE,
                    CMD_CLEAR);
      5'd17: w = uw(ACT_JUMP, SRC_VALUE, 1'b0, 1'b0, 1'b0, LAST_NO, COND_NO_DIGITS, PC_IDLE,
                    8'h00);
      5'd18: w = uw(ACT_EMIT, SRC_DIGIT, 1'b1, 1'b1, 1'b0, LAST_NO, COND_NEXT, PC_IDLE, 8'h00);
      5'd19: w = uw(ACT_EMIT, SRC_DIGIT, 1'b0, 1'b1, 1'b1, LAST_ONE_DIGIT, COND_MORE_DIGITS,
                    PC_DIGIT_OUT, 8'h00);
      default: w = uw(ACT_JUMP, SRC_VALUE, 1'b0, 1'b0, 1'b0, LAST_NO, COND_ALWAYS, PC_IDLE,
                      8'h00);
    endcase
    return w;
  endfunction

endpackage

[rtl/lcdns_if.sv]
// Valid/ready channel interfaces for input items and output nibbles.
interface lcdns_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

interface lcdns_out_if;
  logic       valid;
  logic       ready;
  logic       register_select;
  logic [3:0] nibble;
  logic       last;

  modport source (output valid, output register_select, output nibble, output last,
                  input ready);
  modport sink   (input valid, input register_select, input nibble, input last,
                  output ready);
endinterface

[rtl/lcdns_digits.sv]
// Decimal digit unit: one divide-by-ten step per cycle into a digit stack.
module lcdns_digits import lcdns_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dig_ctrl_t   ctrl_i,
  input  logic [15:0] value_i,
  output dig_stat_t   stat_o
);

  logic [15:0] work_q;
  cnt_t        count_q;
  logic [3:0]  stack_q [DIGITS];

  logic [32:0] prod;
  logic [15:0] quot;
  logic [15:0] quot10;
  logic [15:0] rem;

  always_comb begin
    prod   = 33'(work_q) * 33'(DIV10_RECIP);
    quot   = 16'(prod[32:DIV10_SHIFT]);
    quot10 = (quot << 3) + (quot << 1);
    rem    = work_q - quot10;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (ctrl_i.load) begin
      count_q <= '0;
    end else if (ctrl_i.step) begin
      count_q <= count_q + cnt_t'(1);
    end else if (ctrl_i.pop) begin
      count_q <= count_q - cnt_t'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      work_q <= value_i;
    end else if (ctrl_i.step) begin
      work_q     <= quot;
      stack_q[0] <= rem[3:0];
      for (int i = 1; i < DIGITS; i++) begin
        stack_q[i] <= stack_q[i-1];
      end
    end else if (ctrl_i.pop) begin
      for (int i = 0; i < DIGITS - 1; i++) begin
        stack_q[i] <= stack_q[i+1];
      end
    end
  end

  assign stat_o.more  = (work_q != '0);
  assign stat_o.count = count_q;
  assign stat_o.top   = stack_q[0];

endmodule

[rtl/lcd_nibble_write_sequencer.sv]
// Top level: microcoded sequencer that turns display operations into nibble writes.
//
// in_i carries one operation per transaction: command byte, character byte,
// show number or init sequence. out_o carries one nibble write per transaction
// with its register-select bit and a last flag on the final nibble of the item.
// Every byte goes out high nibble first.
// A ROM program stepped by a program counter does the work, one step per cycle
// except while it waits for input or for the receiver to take a nibble.
// For show number the program runs the divide-by-ten steps, one per decimal
// digit (d digits, up to 5), writes a clear command unless the number equals
// the last one shown, then writes the digits, with last on the final nibble.
// Digit conversion runs one divide-by-ten per cycle, most significant digit out
// first from a small stack.
// in_i.ready is high only while the sequencer waits at its first step.
// When the receiver stalls, the nibble holds in the output register and the
// program stops on its current emit step.
// Reset returns the program to its idle step, empties the output register and
// clears the last shown number to zero.
module lcd_nibble_write_sequencer import lcdns_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  lcdns_in_if.sink    in_i,
  lcdns_out_if.source out_o
);

  pc_t        pc_q, pc_d;
  logic [7:0] byte_q;
  logic       same_q;
  logic [31:0] shown_q;
  logic       out_valid_q;
  logic       rs_q;
  logic [3:0] nib_q;
  logic       last_q;

  uword_t     w;
  dig_ctrl_t  dig_ctrl;
  dig_stat_t  dig_stat;
  logic       fire;
  logic       accept;
  logic       out_free;
  logic       cond_true;
  logic [7:0] src_byte;
  logic [3:0] nib_d;
  logic       last_d;
  logic       emit;

  lcdns_digits u_digits (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (dig_ctrl),
    .value_i (in_i.value[15:0]),
    .stat_o  (dig_stat)
  );

  assign w        = ucode(pc_q);
  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (w.act == ACT_WAIT);
  assign accept   = in_i.valid && in_i.ready;

  always_comb begin
    fire = 1'b1;
    unique case (w.act)
      ACT_WAIT: fire = in_i.valid;
      ACT_EMIT: fire = out_free;
      ACT_DIV:  fire = 1'b1;
      ACT_JUMP: fire = 1'b1;
      default:  fire = 1'b1;
    endcase

    unique case (w.cond)
      COND_NEXT:        cond_true = 1'b0;
      COND_ALWAYS:      cond_true = 1'b1;
      COND_DIV_MORE:    cond_true = dig_stat.more;
      COND_SAME_NUMBER: cond_true = same_q;
      COND_NO_DIGITS:   cond_true = (dig_stat.count == '0);
      COND_MORE_DIGITS: cond_true = (dig_stat.count > cnt_t'(1));
      default:          cond_true = 1'b1;
    endcase

    pc_d = pc_q;
    if (fire) begin
      if (w.act == ACT_WAIT) begin
        pc_d = entry(op_e'(in_i.operation));
      end else if (cond_true) begin
        pc_d = w.target;
      end else begin
        pc_d = pc_q + pc_t'(1);
      end
    end

    emit = fire && (w.act == ACT_EMIT);

    dig_ctrl.load = accept && (op_e'(in_i.operation) == OP_NUMBER);
    dig_ctrl.step = (w.act == ACT_DIV) && dig_stat.more;
    dig_ctrl.pop  = emit && w.pop;

    case (w.src)
      SRC_VALUE: src_byte = byte_q;
      SRC_CONST: src_byte = w.konst;
      SRC_DIGIT: src_byte = {ASCII_DIGIT_HI, dig_stat.top};
      default:   src_byte = byte_q;
    endcase
    nib_d = w.hi ? src_byte[7:4] : src_byte[3:0];

    unique case (w.last)
      LAST_NO:        last_d = 1'b0;
      LAST_YES:       last_d = 1'b1;
      LAST_NO_DIGITS: last_d = (dig_stat.count == '0);
      LAST_ONE_DIGIT: last_d = (dig_stat.count == cnt_t'(1));
      default:        last_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= PC_IDLE;
      out_valid_q <= 1'b0;
      shown_q     <= '0;
    end else begin
      pc_q <= pc_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (dig_ctrl.load) begin
        shown_q <= in_i.value;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= in_i.value[7:0];
      same_q <= (shown_q == in_i.value);
    end
    if (emit) begin
      rs_q   <= w.rs;
      nib_q  <= nib_d;
      last_q <= last_d;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.register_select = rs_q;
  assign out_o.nibble          = nib_q;
  assign out_o.last            = last_q;

endmodule
